@@ rtl/vdt_pkg.sv @@
// ----------------------------------------------------------------------------
// vdt_pkg
// Shared types, field widths and float compare helper for the vertex table.
// ----------------------------------------------------------------------------
package vdt_pkg;

  localparam int CoordW = 32;
  localparam int IndexW = 10;
  localparam int CountW = 11;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [IndexW-1:0] index_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic load;    // latch accepted word, optionally empty the table
    logic scan;    // advance the search by one entry
    logic commit;  // decide match/append/full and load the result
  } vdt_cmd_t;

  typedef struct packed {
    logic hit;     // registered entry equals the held vertex
    logic done;    // every filled entry checked, none matched
  } vdt_status_t;

  function automatic logic is_nan(input coord_t b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // IEEE equality on bit patterns: NaN never equal, +0 == -0
  function automatic logic feq(input coord_t a, input coord_t b);
    logic r;
    if (is_nan(a) || is_nan(b)) begin
      r = 1'b0;
    end else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
      r = 1'b1;
    end else begin
      r = (a == b);
    end
    return r;
  endfunction

endpackage

@@ rtl/vdt_if.sv @@
// ----------------------------------------------------------------------------
// vdt_in_if / vdt_out_if
// Valid/ready channels carrying vertex words and lookup result words.
// ----------------------------------------------------------------------------
interface vdt_in_if;
  import vdt_pkg::*;

  logic   valid;
  logic   ready;
  logic   start_new_mesh;
  coord_t x_bits;
  coord_t y_bits;
  coord_t z_bits;

  modport source (output valid, start_new_mesh, x_bits, y_bits, z_bits, input ready);
  modport sink   (input valid, start_new_mesh, x_bits, y_bits, z_bits, output ready);
endinterface

interface vdt_out_if;
  import vdt_pkg::*;

  logic   valid;
  logic   ready;
  index_t vertex_index;
  logic   was_new;
  logic   table_full;
  count_t unique_count;

  modport source (output valid, vertex_index, was_new, table_full, unique_count,
                  input ready);
  modport sink   (input valid, vertex_index, was_new, table_full, unique_count,
                  output ready);
endinterface

@@ rtl/vdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// vdt_ctrl
// Sequencer: accepts a word, drives the scan, commits and holds the result.
// ----------------------------------------------------------------------------
module vdt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vdt_pkg::vdt_cmd_t    cmd,
  input  vdt_pkg::vdt_status_t status
);
  import vdt_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state_r, state_nxt;
  logic out_vld_r, out_vld_nxt;
  logic out_free;

  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.hit || status.done) begin
          if (out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.commit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

@@ rtl/vdt_datapath.sv @@
// ----------------------------------------------------------------------------
// vdt_datapath
// Vertex store, scan pointer, compare on registered read data and result registers.
// ----------------------------------------------------------------------------
module vdt_datapath #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vdt_pkg::vdt_cmd_t    cmd,
  output vdt_pkg::vdt_status_t status,
  input  logic                 start_new_mesh,
  input  vdt_pkg::coord_t      x_bits,
  input  vdt_pkg::coord_t      y_bits,
  input  vdt_pkg::coord_t      z_bits,
  output vdt_pkg::index_t      vertex_index,
  output logic                 was_new,
  output logic                 table_full,
  output vdt_pkg::count_t      unique_count
);
  import vdt_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = 3 * CoordW;

  logic [EW-1:0] mem [MAX_POINTS];

  coord_t        x_r, y_r, z_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r;
  logic [EW-1:0] rd_data_r;
  index_t        idx_r;
  logic          was_new_r;
  logic          full_r;
  count_t        ucount_r;

  logic          rd_en;
  logic          match;
  logic          room;
  logic          append;
  logic [AW-1:0] idx_sel;
  logic [31:0]   idx_wide;
  logic [31:0]   cnt_wide;

  assign rd_en  = cmd.scan && (ptr_r < count_r);
  assign match  = feq(rd_data_r[EW-1 -: CoordW], x_r)
               && feq(rd_data_r[2*CoordW-1 -: CoordW], y_r)
               && feq(rd_data_r[CoordW-1:0], z_r);
  assign room   = count_r < CW'(MAX_POINTS);

  assign status.hit  = rd_vld_r && match;
  assign status.done = !rd_vld_r && (ptr_r == count_r);

  assign append = cmd.commit && !status.hit && room;

  always_comb begin
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    rd_vld_nxt = rd_vld_r;
    if (cmd.load) begin
      if (start_new_mesh) begin
        count_nxt = '0;
      end
      ptr_nxt    = '0;
      rd_vld_nxt = 1'b0;
    end else if (cmd.scan) begin
      rd_vld_nxt = rd_en;
      if (rd_en) begin
        ptr_nxt = ptr_r + CW'(1);
      end
    end else if (append) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    if (status.hit) begin
      idx_sel = rd_idx_r;
    end else if (room) begin
      idx_sel = count_r[AW-1:0];
    end else begin
      idx_sel = '0;
    end
    idx_wide = 32'(idx_sel);
    cnt_wide = 32'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (append) begin
      mem[count_r[AW-1:0]] <= {x_r, y_r, z_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[ptr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= x_bits;
      y_r <= y_bits;
      z_r <= z_bits;
    end
    if (rd_en) begin
      rd_idx_r <= ptr_r[AW-1:0];
    end
    if (cmd.commit) begin
      idx_r     <= idx_wide[IndexW-1:0];
      was_new_r <= !status.hit && room;
      full_r    <= !status.hit && !room;
      ucount_r  <= cnt_wide[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  assign vertex_index = idx_r;
  assign was_new      = was_new_r;
  assign table_full   = full_r;
  assign unique_count = ucount_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("stored count above table depth");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (CW'(rd_idx_r) < count_r))
    else $error("pending read beyond filled entries");

  a_append_incr: assert property (@(posedge clk) disable iff (!rst_n)
    append |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not bump count");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !(was_new_r && full_r))
    else $error("new and full flags both set");

endmodule

@@ rtl/vertex_dedup_table.sv @@
// ----------------------------------------------------------------------------
// vertex_dedup_table
// Vertex de-duplication table with linear search over filled entries.
// ----------------------------------------------------------------------------
// One vertex word is taken at a time. After acceptance the block reads the
// vertex store one entry per cycle through its single registered read port
// and compares each against the held vertex; the search stops at the first
// matching entry, or after all N filled entries on a miss, N being at most
// MAX_POINTS (with an empty table no entry is read). A finished result waits
// in the output register while the next word is accepted. Start of a new
// mesh empties the table instantly; stored data is not cleared, only the fill
// count, so no clearing pass follows reset.
module vertex_dedup_table #(
  parameter int MAX_POINTS = 1024
) (
  input logic        clk,
  input logic        rst_n,
  vdt_in_if.sink     in_ch,
  vdt_out_if.source  out_ch
);
  import vdt_pkg::*;

  vdt_cmd_t    cmd;
  vdt_status_t status;

  vdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  vdt_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .start_new_mesh (in_ch.start_new_mesh),
    .x_bits         (in_ch.x_bits),
    .y_bits         (in_ch.y_bits),
    .z_bits         (in_ch.z_bits),
    .vertex_index   (out_ch.vertex_index),
    .was_new        (out_ch.was_new),
    .table_full     (out_ch.table_full),
    .unique_count   (out_ch.unique_count)
  );

endmodule
